>>> rtl/utf8ct_pkg.sv
// Shared types and constants for the UTF-8 character translation core.
// No dependencies; all other files except the checker refer to it by scoped names.
`default_nettype none

package utf8ct_pkg;

  localparam int unsigned TableEntries = 64;
  localparam int unsigned CpW          = 21;
  localparam int unsigned ByteW        = 8;

  typedef enum logic [1:0] {
    OpClear = 2'd0,
    OpAdd   = 2'd1,
    OpText  = 2'd2
  } op_e;

  // One table entry as held in the value memory.
  typedef struct packed {
    logic           is_delete;
    logic [CpW-1:0] value;
  } entry_t;

  // What the byte gatherer makes of one text byte.
  typedef struct packed {
    logic [3:0][ByteW-1:0] raw;
    logic [2:0]            raw_cnt;
    logic                  lookup;
    logic [CpW-1:0]        cp;
  } gath_t;

  // Request held in the table stage.
  typedef struct packed {
    op_e                   op;
    logic [CpW-1:0]        cp;
    logic [CpW-1:0]        value;
    logic                  has_value;
    logic [3:0][ByteW-1:0] raw;
    logic [2:0]            raw_cnt;
    logic                  lookup;
    logic                  eos;
  } item_t;

  // Request held in the compose stage.
  typedef struct packed {
    logic [3:0][ByteW-1:0] raw;
    logic [2:0]            raw_cnt;
    logic                  hit;
    logic                  eos;
    logic                  ovf;
  } s2_t;

endpackage

`default_nettype wire

>>> rtl/utf8_character_translate_core.sv
// Top level of the UTF-8 character translation core: gatherer, table stage, compose stage.
// Depends on utf8ct_pkg, utf8ct_gather, utf8ct_table and utf8ct_emit.
`default_nettype none

// Translates a UTF-8 byte stream through a loadable codepoint table, as SQL translate does.
// Requests enter on the slave stream with the operation in tuser: clear, add entry, or a text
// byte with tlast marking the end of the string. One request is taken per cycle while the
// stages ahead are free; a codepoint that leaves as more than one byte can hold the input back,
// since the output register sends one byte a cycle while the receiver is ready. A text byte
// passes the gatherer, the table stage (a parallel match over all keys plus a registered read
// of the value memory) and the compose stage, and its bytes are offered from the output
// register. The table comes out of reset empty and needs no clearing pass.

module utf8_character_translate_core #(
  parameter int unsigned TABLE_ENTRIES = utf8ct_pkg::TableEntries
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [55:0] s_axis_tdata_i,  // key_codepoint, value_codepoint, has_value,
                                            // text_byte, zero fill
  input  wire logic        s_axis_tlast_i,  // end_of_string
  input  wire logic [1:0]  s_axis_tuser_i,  // operation
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [7:0]       m_axis_tdata_o,  // out_byte
  output logic             m_axis_tlast_o,  // last_of_run
  output logic [2:0]       m_axis_tuser_o   // byte_valid, string_end, table_overflow
);

  utf8ct_pkg::gath_t  gath;
  utf8ct_pkg::item_t  s1_q, s1_d;
  logic               s1_valid_q;
  utf8ct_pkg::s2_t    s2_d;
  utf8ct_pkg::entry_t rdata;
  logic               s1_fire, accept, known_op, is_text, s2_ready, tbl_hit, tbl_ovf;

  assign is_text  = (s_axis_tuser_i == utf8ct_pkg::OpText);
  assign known_op = (s_axis_tuser_i == utf8ct_pkg::OpClear) ||
                    (s_axis_tuser_i == utf8ct_pkg::OpAdd) || is_text;

  assign s1_fire = s1_valid_q && ((s1_q.op != utf8ct_pkg::OpText) || s2_ready);
  assign s_axis_tready_o = !s1_valid_q || s1_fire;
  assign accept  = s_axis_tvalid_i && s_axis_tready_o;

  utf8ct_gather u_gather (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .update_i(accept && is_text),
    .byte_i  (s_axis_tdata_i[50:43]),
    .eos_i   (s_axis_tlast_i),
    .gath_o  (gath)
  );

  always_comb begin
    s1_d.op        = utf8ct_pkg::op_e'(s_axis_tuser_i);
    s1_d.cp        = is_text ? gath.cp : s_axis_tdata_i[20:0];
    s1_d.value     = s_axis_tdata_i[41:21];
    s1_d.has_value = s_axis_tdata_i[42];
    s1_d.raw       = gath.raw;
    s1_d.raw_cnt   = gath.raw_cnt;
    s1_d.lookup    = gath.lookup;
    s1_d.eos       = s_axis_tlast_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept && known_op) begin
      s1_valid_q <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && known_op) begin
      s1_q <= s1_d;
    end
  end

  utf8ct_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .item_i (s1_q),
    .hit_o  (tbl_hit),
    .ovf_o  (tbl_ovf),
    .rdata_o(rdata)
  );

  assign s2_d.raw     = s1_q.raw;
  assign s2_d.raw_cnt = s1_q.raw_cnt;
  assign s2_d.hit     = s1_q.lookup && tbl_hit;
  assign s2_d.eos     = s1_q.eos;
  assign s2_d.ovf     = tbl_ovf;

  utf8ct_emit u_emit (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (s1_fire && (s1_q.op == utf8ct_pkg::OpText)),
    .s2_i           (s2_d),
    .rdata_i        (rdata),
    .ready_o        (s2_ready),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

>>> rtl/utf8ct_gather.sv
// UTF-8 byte gatherer: holds the partial sequence and decodes each text byte.
// Depends on utf8ct_pkg for the gatherer result type.
`default_nettype none

module utf8ct_gather (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       update_i,
  input  wire logic [utf8ct_pkg::ByteW-1:0] byte_i,
  input  wire logic                       eos_i,
  output utf8ct_pkg::gath_t               gath_o
);

  logic [2:0][utf8ct_pkg::ByteW-1:0] pend_q, pend_d;
  logic [1:0]                        pend_cnt_q, pend_cnt_d;
  logic [2:0]                        exp_len_q, exp_len_d;

  logic [3:0][utf8ct_pkg::ByteW-1:0] raw, seq;
  logic [2:0]                        n;
  logic [1:0]                        pos;
  logic [2:0]                        lead;
  logic                              cont, ok, lk;
  logic [utf8ct_pkg::CpW-1:0]        cp;
  logic [10:0]                       cp2;
  logic [15:0]                       cp3;
  logic [20:0]                       cp4;

  always_comb begin
    cont = (byte_i[7:6] == 2'b10);
    if (byte_i[7:5] == 3'b110) begin
      lead = 3'd2;
    end else if (byte_i[7:4] == 4'b1110) begin
      lead = 3'd3;
    end else if (byte_i[7:3] == 5'b11110) begin
      lead = 3'd4;
    end else begin
      lead = 3'd0;
    end

    seq = '0;
    for (int j = 0; j < 3; j++) begin
      seq[j] = pend_q[j];
    end
    seq[pend_cnt_q] = byte_i;
    cp2 = {seq[0][4:0], seq[1][5:0]};
    cp3 = {seq[0][3:0], seq[1][5:0], seq[2][5:0]};
    cp4 = {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};

    raw        = '0;
    n          = '0;
    pos        = '0;
    lk         = 1'b0;
    ok         = 1'b0;
    cp         = '0;
    pend_d     = pend_q;
    pend_cnt_d = pend_cnt_q;
    exp_len_d  = exp_len_q;

    if (pend_cnt_q != 2'd0) begin
      if (cont) begin
        if ({1'b0, pend_cnt_q} + 3'd1 == exp_len_q) begin
          unique case (pend_cnt_q)
            2'd1: begin
              cp = {10'b0, cp2};
              ok = (cp2[10:7] != 4'd0);
            end
            2'd2: begin
              cp = {5'b0, cp3};
              ok = (cp3 >= 16'h0800) && (cp3[15:11] != 5'b11011);
            end
            default: begin
              cp = cp4;
              ok = (cp4 >= 21'h010000) && (cp4 <= 21'h10FFFF);
            end
          endcase
          raw        = seq;
          n          = {1'b0, pend_cnt_q} + 3'd1;
          lk         = ok;
          pend_cnt_d = 2'd0;
          exp_len_d  = 3'd0;
        end else begin
          pend_d[pend_cnt_q] = byte_i;
          pend_cnt_d         = pend_cnt_q + 2'd1;
        end
      end else begin
        // A broken sequence goes out raw before the new byte.
        for (int j = 0; j < 3; j++) begin
          if (2'(j) < pend_cnt_q) begin
            raw[j] = pend_q[j];
          end
        end
        n = {1'b0, pend_cnt_q};
        if (lead != 3'd0) begin
          pend_d[0]  = byte_i;
          pend_cnt_d = 2'd1;
          exp_len_d  = lead;
        end else begin
          raw[n[1:0]] = byte_i;
          n           = n + 3'd1;
          pend_cnt_d  = 2'd0;
          exp_len_d   = 3'd0;
        end
      end
    end else if (!byte_i[7]) begin
      raw[0] = byte_i;
      n      = 3'd1;
      lk     = 1'b1;
      cp     = {13'b0, byte_i};
    end else if (lead != 3'd0) begin
      pend_d[0]  = byte_i;
      pend_cnt_d = 2'd1;
      exp_len_d  = lead;
    end else begin
      raw[0] = byte_i;
      n      = 3'd1;
    end

    if (eos_i) begin
      for (int j = 0; j < 3; j++) begin
        if (2'(j) < pend_cnt_d) begin
          pos      = n[1:0] + 2'(j);
          raw[pos] = pend_d[j];
        end
      end
      n          = n + {1'b0, pend_cnt_d};
      pend_cnt_d = 2'd0;
      exp_len_d  = 3'd0;
    end
  end

  assign gath_o.raw     = raw;
  assign gath_o.raw_cnt = n;
  assign gath_o.lookup  = lk;
  assign gath_o.cp      = cp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_cnt_q <= 2'd0;
      exp_len_q  <= 3'd0;
    end else if (update_i) begin
      pend_cnt_q <= pend_cnt_d;
      exp_len_q  <= exp_len_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (update_i) begin
      pend_q <= pend_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/utf8ct_table.sv
// Mapping table: key registers with a parallel match, value memory, fill count, overflow flag.
// Depends on utf8ct_pkg for the request and entry types.
`default_nettype none

module utf8ct_table #(
  parameter int unsigned TABLE_ENTRIES = utf8ct_pkg::TableEntries
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              fire_i,
  input  wire utf8ct_pkg::item_t item_i,
  output logic                   hit_o,
  output logic                   ovf_o,
  output utf8ct_pkg::entry_t     rdata_o
);

  localparam int unsigned IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CntW = $clog2(TABLE_ENTRIES + 1);

  logic [utf8ct_pkg::CpW-1:0] key_q [TABLE_ENTRIES];
  utf8ct_pkg::entry_t         mem_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]   used_q;
  logic [CntW-1:0]            count_q;
  logic                       ovf_q;

  logic [TABLE_ENTRIES-1:0]   match;
  logic [IdxW-1:0]            match_idx;
  logic                       full, do_add, do_write, do_read;
  logic [IdxW-1:0]            wr_idx;
  utf8ct_pkg::entry_t         wr_entry;

  // Keys are unique among used entries, so OR-ing the matching indices gives the one hit.
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = used_q[i] && (key_q[i] == item_i.cp);
      if (match[i]) begin
        match_idx = match_idx | IdxW'(i);
      end
    end
  end

  assign hit_o    = |match;
  assign full     = (count_q == CntW'(TABLE_ENTRIES));
  assign do_add   = fire_i && (item_i.op == utf8ct_pkg::OpAdd) && !hit_o;
  assign do_write = do_add && !full;
  assign do_read  = fire_i && (item_i.op == utf8ct_pkg::OpText);
  assign wr_idx   = count_q[IdxW-1:0];

  assign wr_entry.is_delete = !item_i.has_value;
  assign wr_entry.value     = item_i.has_value ? item_i.value : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (fire_i && (item_i.op == utf8ct_pkg::OpClear)) begin
      used_q  <= '0;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else if (do_write) begin
      used_q[wr_idx] <= 1'b1;
      count_q        <= count_q + CntW'(1);
    end else if (do_add) begin
      ovf_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      key_q[wr_idx] <= item_i.cp;
      mem_q[wr_idx] <= wr_entry;
    end
    if (do_read) begin
      rdata_o <= mem_q[match_idx];
    end
  end

  assign ovf_o = ovf_q;

endmodule

`default_nettype wire

>>> rtl/utf8ct_emit.sv
// Compose stage and output register: re-encodes mapped codepoints; one byte a cycle when taken.
// Depends on utf8ct_pkg for the stage and entry types.
`default_nettype none

module utf8ct_emit (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         load_i,
  input  wire utf8ct_pkg::s2_t              s2_i,
  input  wire utf8ct_pkg::entry_t           rdata_i,
  output logic                              ready_o,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  output logic [7:0]                        m_axis_tdata_o,  // out_byte
  output logic                              m_axis_tlast_o,  // last_of_run
  output logic [2:0]                        m_axis_tuser_o   // byte_valid, string_end,
                                                             // table_overflow
);

  utf8ct_pkg::s2_t                   s2_q;
  logic                              s2_valid_q;
  logic [3:0][utf8ct_pkg::ByteW-1:0] ob_bytes_q;
  logic [1:0]                        ob_idx_q, ob_last_q;
  logic                              ob_valid_q, ob_bv_q, ob_eos_q, ob_ovf_q;

  logic [3:0][utf8ct_pkg::ByteW-1:0] bytes;
  logic [2:0]                        cnt;
  logic                              bv;
  logic [utf8ct_pkg::CpW-1:0]        v;
  logic                              take, ob_at_last, ob_free, s2_adv;

  assign v = rdata_i.value;

  always_comb begin
    bytes = s2_q.raw;
    cnt   = s2_q.raw_cnt;
    bv    = 1'b1;
    if (s2_q.hit) begin
      bytes = '0;
      if (rdata_i.is_delete) begin
        cnt = 3'd0;
      end else if (v[20:7] == '0) begin
        bytes[0] = v[7:0];
        cnt      = 3'd1;
      end else if (v[20:11] == '0) begin
        bytes[0] = {3'b110, v[10:6]};
        bytes[1] = {2'b10, v[5:0]};
        cnt      = 3'd2;
      end else if (v[20:16] == '0) begin
        bytes[0] = {4'b1110, v[15:12]};
        bytes[1] = {2'b10, v[11:6]};
        bytes[2] = {2'b10, v[5:0]};
        cnt      = 3'd3;
      end else begin
        bytes[0] = {5'b11110, v[20:18]};
        bytes[1] = {2'b10, v[17:12]};
        bytes[2] = {2'b10, v[11:6]};
        bytes[3] = {2'b10, v[5:0]};
        cnt      = 3'd4;
      end
    end
    // A string that ends with nothing to send still gets an empty end marker.
    if ((cnt == 3'd0) && s2_q.eos) begin
      bytes = '0;
      cnt   = 3'd1;
      bv    = 1'b0;
    end
  end

  assign take       = ob_valid_q && m_axis_tready_i;
  assign ob_at_last = (ob_idx_q == ob_last_q);
  assign ob_free    = !ob_valid_q || (take && ob_at_last);
  assign s2_adv     = s2_valid_q && ob_free;
  assign ready_o    = !s2_valid_q || s2_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      ob_valid_q <= 1'b0;
      ob_idx_q   <= 2'd0;
    end else begin
      if (load_i) begin
        s2_valid_q <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      if (s2_adv && (cnt != 3'd0)) begin
        ob_valid_q <= 1'b1;
        ob_idx_q   <= 2'd0;
      end else if (take && ob_at_last) begin
        ob_valid_q <= 1'b0;
      end else if (take) begin
        ob_idx_q <= ob_idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      s2_q <= s2_i;
    end
    if (s2_adv && (cnt != 3'd0)) begin
      ob_bytes_q <= bytes;
      ob_last_q  <= 2'(cnt - 3'd1);
      ob_bv_q    <= bv;
      ob_eos_q   <= s2_q.eos;
      ob_ovf_q   <= s2_q.ovf;
    end
  end

  assign m_axis_tvalid_o = ob_valid_q;
  assign m_axis_tdata_o  = ob_bytes_q[ob_idx_q];
  assign m_axis_tlast_o  = ob_at_last;
  assign m_axis_tuser_o  = {ob_ovf_q, ob_eos_q && ob_at_last, ob_bv_q};

endmodule

`default_nettype wire

>>> rtl/utf8ct_checker.sv
// Port-level checks for the UTF-8 character translation core, bound to its top level.
// Depends on utf8_character_translate_core for the bind target.
`default_nettype none

module utf8ct_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       m_axis_tvalid_o,
  input wire logic       m_axis_tready_i,
  input wire logic [7:0] m_axis_tdata_o,
  input wire logic       m_axis_tlast_o,
  input wire logic [2:0] m_axis_tuser_o
);

  // A stalled result stays offered.
  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result withdrawn while stalled");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // An empty end marker is a lone, zero, string-ending result.
  a_marker_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[0] |->
      (m_axis_tdata_o == 8'h00) && m_axis_tlast_o && m_axis_tuser_o[1])
    else $error("malformed end marker");

  // The end of a string closes the run of the byte that caused it.
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[1] |-> m_axis_tlast_o)
    else $error("string end before last result of its request");

endmodule

bind utf8_character_translate_core utf8ct_checker u_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tlast_o (m_axis_tlast_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);

`default_nettype wire

>>> verif/utf8_character_translate_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for utf8_character_translate_core: directed and random requests,
// with a translation scoreboard that predicts every output byte. Depends on utf8ct_pkg.

module utf8_character_translate_core_tb;

  localparam logic [1:0] OpUnused     = 2'd3;
  localparam int unsigned PoolSize    = 16;
  localparam int unsigned TotalItems  = 350;
  localparam int unsigned DrainCycles = 10;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned MaxReports  = 10;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       has_byte;
    logic       run_last;
    logic       str_end;
    logic       ovf;
  } out_beat_t;

  class translation_scoreboard;
    logic [utf8ct_pkg::CpW-1:0] keys   [utf8ct_pkg::TableEntries];
    logic [utf8ct_pkg::CpW-1:0] values [utf8ct_pkg::TableEntries];
    bit             is_del [utf8ct_pkg::TableEntries];
    bit             used   [utf8ct_pkg::TableEntries];
    int unsigned    fill;
    logic [23:0]    held;
    int unsigned    held_cnt;
    int unsigned    want_len;
    bit             overflow;
    out_beat_t      run[$];
    out_beat_t      awaited_bytes[$];
    int unsigned    faults;

    function new();
      foreach (used[i]) used[i] = 1'b0;
      fill     = 0;
      held     = '0;
      held_cnt = 0;
      want_len = 0;
      overflow = 1'b0;
      faults   = 0;
    endfunction

    static function int unsigned encode_utf8(logic [utf8ct_pkg::CpW-1:0] v,
                                             output logic [3:0][7:0] b);
      b = '0;
      if (v < 'h80) begin
        b[0] = v[7:0];
        return 1;
      end
      if (v < 'h800) begin
        b[0] = {3'b110, v[10:6]};
        b[1] = {2'b10, v[5:0]};
        return 2;
      end
      if (v < 'h10000) begin
        b[0] = {4'b1110, v[15:12]};
        b[1] = {2'b10, v[11:6]};
        b[2] = {2'b10, v[5:0]};
        return 3;
      end
      // Large replacement values keep only the top three bits in the lead byte.
      b[0] = {5'b11110, v[20:18]};
      b[1] = {2'b10, v[17:12]};
      b[2] = {2'b10, v[11:6]};
      b[3] = {2'b10, v[5:0]};
      return 4;
    endfunction

    function int find(logic [utf8ct_pkg::CpW-1:0] cp);
      for (int i = 0; i < utf8ct_pkg::TableEntries; i++) begin
        if (used[i] && keys[i] == cp) return i;
      end
      return -1;
    endfunction

    function void emit(logic [7:0] b);
      out_beat_t beat;
      beat = '{byte_val: b, has_byte: 1'b1, run_last: 1'b0, str_end: 1'b0, ovf: overflow};
      run.push_back(beat);
    endfunction

    function void flush_held();
      for (int i = held_cnt; i > 0; i--) emit(held[8*(i-1) +: 8]);
      held     = '0;
      held_cnt = 0;
      want_len = 0;
    endfunction

    function void finish_seq(logic [3:0][7:0] seq, int unsigned len);
      int unsigned     cp;
      bit              ok;
      int              hit;
      int unsigned     n;
      logic [3:0][7:0] enc;
      if (len == 1) begin
        cp = 32'(seq[0]);
        ok = 1'b1;
      end else begin
        cp = 32'(seq[0] & ((len == 2) ? 8'h1F : (len == 3) ? 8'h0F : 8'h07));
        for (int k = 1; k < len; k++) cp = (cp << 6) | 32'(seq[k][5:0]);
        if (len == 2) ok = cp >= 'h80;
        else if (len == 3) ok = cp >= 'h800 && (cp < 'hD800 || cp > 'hDFFF);
        else ok = cp >= 'h10000 && cp <= 'h10FFFF;
      end
      // Ill-formed sequences skip the table and go out as they came.
      hit = ok ? find(utf8ct_pkg::CpW'(cp)) : -1;
      if (hit < 0) begin
        for (int k = 0; k < len; k++) emit(seq[k]);
      end else if (!is_del[hit]) begin
        n = encode_utf8(values[hit], enc);
        for (int k = 0; k < n; k++) emit(enc[k]);
      end
    endfunction

    function void translate_request(logic [1:0] op, logic [utf8ct_pkg::CpW-1:0] key,
                                    logic [utf8ct_pkg::CpW-1:0] val,
                                    logic hv, logic [7:0] b, logic eos);
      bit              cont;
      int unsigned     lead;
      logic [3:0][7:0] seq;
      run.delete();
      seq = '0;
      case (op)
        utf8ct_pkg::OpClear: begin
          foreach (used[i]) used[i] = 1'b0;
          fill     = 0;
          overflow = 1'b0;
        end
        utf8ct_pkg::OpAdd: begin
          if (find(key) < 0) begin
            if (fill >= utf8ct_pkg::TableEntries) begin
              overflow = 1'b1;
            end else begin
              keys[fill]   = key;
              values[fill] = hv ? val : '0;
              is_del[fill] = !hv;
              used[fill]   = 1'b1;
              fill++;
            end
          end
        end
        utf8ct_pkg::OpText: begin
          cont = b[7:6] == 2'b10;
          if (b[7:5] == 3'b110) lead = 2;
          else if (b[7:4] == 4'b1110) lead = 3;
          else if (b[7:3] == 5'b11110) lead = 4;
          else lead = 0;
          if (held_cnt > 0) begin
            if (cont) begin
              if (held_cnt + 1 == want_len) begin
                for (int i = 0; i < held_cnt; i++) seq[i] = held[8*(held_cnt-1-i) +: 8];
                seq[held_cnt] = b;
                lead = held_cnt + 1;
                held     = '0;
                held_cnt = 0;
                want_len = 0;
                finish_seq(seq, lead);
              end else begin
                held = {held[15:0], b};
                held_cnt++;
              end
            end else begin
              // A truncated sequence goes out raw before the byte that broke it.
              flush_held();
              if (lead != 0) begin
                held     = {16'h0, b};
                held_cnt = 1;
                want_len = lead;
              end else begin
                emit(b);
              end
            end
          end else if (!b[7]) begin
            seq[0] = b;
            finish_seq(seq, 1);
          end else if (lead != 0) begin
            held     = {16'h0, b};
            held_cnt = 1;
            want_len = lead;
          end else begin
            emit(b);
          end
          if (eos) begin
            if (held_cnt > 0) flush_held();
            if (run.size() == 0) begin
              emit(8'h00);
              run[0].has_byte = 1'b0;
            end
            run[run.size()-1].str_end = 1'b1;
          end
          if (run.size() > 0) run[run.size()-1].run_last = 1'b1;
          foreach (run[i]) awaited_bytes.push_back(run[i]);
        end
        default: ;
      endcase
    endfunction

    function void note_fault(string msg);
      faults++;
      if (faults <= MaxReports) $display("%0t: %s", $time, msg);
    endfunction

    function void check_byte(logic [7:0] data, logic last, logic [2:0] user);
      out_beat_t got;
      out_beat_t want;
      got = '{byte_val: data, has_byte: user[0], run_last: last, str_end: user[1], ovf: user[2]};
      if (awaited_bytes.size() == 0) begin
        note_fault($sformatf("output byte %02h with nothing awaited", data));
      end else begin
        want = awaited_bytes.pop_front();
        if (got !== want)
          note_fault($sformatf({"mismatch: expected byte %02h valid %0b last %0b end %0b ",
                                "ovf %0b, got byte %02h valid %0b last %0b end %0b ovf %0b"},
                               want.byte_val, want.has_byte, want.run_last, want.str_end,
                               want.ovf, got.byte_val, got.has_byte, got.run_last,
                               got.str_end, got.ovf));
      end
    endfunction
  endclass

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic [55:0] s_tdata  = '0;
  logic        s_tlast  = 1'b0;
  logic [1:0]  s_tuser  = '0;
  logic        m_tready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [7:0]  m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic [2:0]  m_axis_tuser_o;

  translation_scoreboard sb = new();
  bit             no_idle     = 1'b0;
  bit             hold_output = 1'b0;
  int unsigned    sent_requests = 0;
  int unsigned    cycle_count   = 0;
  logic [utf8ct_pkg::CpW-1:0] cp_pool [PoolSize];

  utf8_character_translate_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[utf8_character_translate_core] ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready)
      sb.check_byte(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
  end

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned idle_len();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic logic [utf8ct_pkg::CpW-1:0] random_cp();
    case ($urandom_range(0, 3))
      0:       return utf8ct_pkg::CpW'($urandom_range(0, 'h7F));
      1:       return utf8ct_pkg::CpW'($urandom_range('h80, 'h7FF));
      2:       return utf8ct_pkg::CpW'($urandom_range('h800, 'hFFFF));
      default: return utf8ct_pkg::CpW'($urandom_range('h10000, 'h10FFFF));
    endcase
  endfunction

  // Output side: random back-pressure, plus one long hold-off on request.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_output) begin
        m_tready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_output = 1'b0;
        m_tready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        m_tready <= 1'b0;
        repeat (idle_len()) @(posedge clk_i);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  task automatic send(logic [1:0] op, logic [utf8ct_pkg::CpW-1:0] key,
                      logic [utf8ct_pkg::CpW-1:0] val, logic hv, logic [7:0] b, logic eos);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat (idle_len()) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {5'b0, b, hv, val, key};
    s_tlast  <= eos;
    s_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.translate_request(op, key, val, hv, b, eos);
    if (op != OpUnused) sent_requests++;
  endtask

  // Fields that a text request does not use carry noise.
  task automatic send_text(logic [7:0] b, logic eos);
    send(utf8ct_pkg::OpText, utf8ct_pkg::CpW'($urandom), utf8ct_pkg::CpW'($urandom),
         1'($urandom), b, eos);
  endtask

  task automatic send_add(logic [utf8ct_pkg::CpW-1:0] key, logic [utf8ct_pkg::CpW-1:0] val,
                          logic hv);
    send(utf8ct_pkg::OpAdd, key, val, hv, 8'($urandom), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_junk(logic [1:0] op, logic eos);
    send(op, utf8ct_pkg::CpW'($urandom), utf8ct_pkg::CpW'($urandom), 1'($urandom),
         8'($urandom), eos);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.awaited_bytes.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic refresh_pool();
    foreach (cp_pool[i]) cp_pool[i] = random_cp();
  endtask

  task automatic load_table(int unsigned n_adds);
    logic [utf8ct_pkg::CpW-1:0] key;
    for (int k = 0; k < n_adds; k++) begin
      key = ($urandom_range(0, 9) < 7) ? cp_pool[$urandom_range(0, PoolSize-1)] : random_cp();
      send_add(key, random_cp(), $urandom_range(0, 3) != 0);
    end
  endtask

  // Mostly well-formed codepoints, most from the pool, with stray bytes and cut-off sequences.
  task automatic send_string(int unsigned n_cp);
    logic [7:0]      bytes[$];
    logic [3:0][7:0] enc;
    logic [utf8ct_pkg::CpW-1:0] cp;
    int unsigned     r;
    int unsigned     len;
    for (int k = 0; k < n_cp; k++) begin
      r = $urandom_range(0, 19);
      if (r < 2) begin
        bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        cp  = ($urandom_range(0, 2) != 0) ? cp_pool[$urandom_range(0, PoolSize-1)] : random_cp();
        len = translation_scoreboard::encode_utf8(cp, enc);
        if (r == 2 && len > 1) len = $urandom_range(1, len - 1);
        for (int j = 0; j < len; j++) bytes.push_back(enc[j]);
      end
    end
    foreach (bytes[j]) send_text(bytes[j], j == bytes.size() - 1);
  endtask

  task automatic send_noise(int unsigned n);
    int unsigned r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 9);
      if (r == 0) send_junk(utf8ct_pkg::OpClear, 1'($urandom));
      else if (r == 1) send_junk(OpUnused, 1'($urandom));
      else if (r == 2) send_add(random_cp(), random_cp(), 1'($urandom_range(0, 1)));
      else send_text(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: the table starts empty after reset.
    send_add(21'h61, 21'h10FFFF, 1'b1);   // maps to a four-byte sequence
    send_add(21'h61, 21'h42, 1'b1);       // same key again, must be ignored
    send_add(21'h62, 21'h1AAAA, 1'b0);    // deletion, value is dropped
    send_add(21'h1F600, 21'hFFFF, 1'b1);
    send(OpUnused, 21'h1FFFFF, 21'h1FFFFF, 1'b1, 8'hFF, 1'b1);
    send_text(8'h61, 1'b0);
    send_text(8'h62, 1'b1);               // deleted last byte leaves a bare end marker
    send_text(8'hF0, 1'b0);
    send_text(8'h9F, 1'b0);
    send_text(8'h98, 1'b0);
    send_text(8'h80, 1'b0);
    send_text(8'hC1, 1'b0);               // overlong
    send_text(8'hBF, 1'b0);
    send_text(8'hED, 1'b0);               // surrogate
    send_text(8'hA0, 1'b0);
    send_text(8'h80, 1'b0);
    send_text(8'hF4, 1'b0);               // above the Unicode range
    send_text(8'h90, 1'b0);
    send_text(8'h80, 1'b0);
    send_text(8'h80, 1'b0);
    send_text(8'h80, 1'b0);               // stray continuation
    send_text(8'hFF, 1'b0);
    send_text(8'hE2, 1'b0);               // cut short by a plain byte
    send_text(8'h82, 1'b0);
    send_text(8'h41, 1'b0);
    send_text(8'hE2, 1'b0);               // cut short by a new lead byte
    send_text(8'hC3, 1'b0);
    send_text(8'hA9, 1'b0);
    send_text(8'hF0, 1'b0);
    send_text(8'h9F, 1'b0);
    send(utf8ct_pkg::OpClear, '0, '0, 1'b0, 8'h00, 1'b0);  // gathered bytes survive a clear
    send_text(8'h98, 1'b0);
    send_text(8'h80, 1'b1);

    // Fill the table past its size, then retry present keys while it is full.
    refresh_pool();
    send_junk(utf8ct_pkg::OpClear, 1'b0);
    for (int k = 0; k < 8; k++) send_add(cp_pool[k], random_cp(), k % 3 != 0);
    for (int k = 8; k < utf8ct_pkg::TableEntries + 4; k++)
      send_add(random_cp(), random_cp(), 1'b1);
    for (int k = 0; k < 4; k++) send_add(cp_pool[k], random_cp(), 1'b1);
    send_string(6);
    send_string(4);
    wait_drained();

    // The random part begins under a long output hold-off.
    hold_output = 1'b1;
    while (sent_requests < TotalItems) begin
      no_idle = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0, 1: begin
          if ($urandom_range(0, 3) != 0) send_junk(utf8ct_pkg::OpClear, 1'($urandom));
          if ($urandom_range(0, 2) == 0) refresh_pool();
          load_table($urandom_range(1, 10));
        end
        2, 3:    send_noise($urandom_range(3, 10));
        default: send_string($urandom_range(1, 8));
      endcase
    end

    wait_drained();
    if (sb.awaited_bytes.size() != 0)
      sb.note_fault($sformatf("%0d output bytes never arrived", sb.awaited_bytes.size()));
    if (sb.faults == 0) begin
      $display("[utf8_character_translate_core] OK");
    end else begin
      $display("[utf8_character_translate_core] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/utf8ct_pkg.sv
rtl/utf8ct_gather.sv
rtl/utf8ct_table.sv
rtl/utf8ct_emit.sv
rtl/utf8_character_translate_core.sv
rtl/utf8ct_checker.sv
verif/utf8_character_translate_core_tb.sv
